// ----- design/sbat_pkg.sv -----
// Shared constants and types for the block address translation pipeline.
// No dependencies.
`default_nettype none

package sbat_pkg;

  localparam int unsigned IdxW     = 24;  // logical block index
  localparam int unsigned QuotW    = 17;  // 2^24 / 170 fits in 17 bits
  localparam int unsigned RemW     = 8;   // remainder of a divide by 170
  localparam int unsigned BlkW     = 25;  // block numbers including hash blocks
  localparam int unsigned OffW     = 37;  // byte offsets
  localparam int unsigned BaseW    = 32;
  localparam int unsigned FsizeW   = 40;
  localparam int unsigned CfgDataW = 40;
  localparam int unsigned BlkShift = 12;  // 4096-byte blocks
  localparam int unsigned ProdW    = 49;  // 24-bit dividend times 25-bit reciprocal
  localparam int unsigned RecipW   = 25;

  // floor(2^32 / 170); the product shifted down is the quotient or one less
  localparam logic [RecipW-1:0] DivRecip   = 25'd25264513;
  localparam logic [8:0]        BlocksL0   = 9'd170;
  localparam logic [OffW+3:0]   TableBytes = 41'd4096;

  typedef enum logic [0:0] {
    REG_BASE_OFFSET = 1'b0,
    REG_FILE_SIZE   = 1'b1
  } sbat_reg_e;

  // Beat handed from the divider chain to the offset stages.
  typedef struct packed {
    logic             valid;
    logic [IdxW-1:0]  idx;    // block index
    logic [QuotW-1:0] quot0;  // idx / 170
    logic [9:0]       quot1;  // idx / 28900
    logic [RemW-1:0]  rem0;   // idx % 170
  } sbat_beat_t;

endpackage

`default_nettype wire

// ----- design/sbat_div170.sv -----
// Two-stage divide by 170: reciprocal multiply, then one correction step.
// Depends on sbat_pkg.
`default_nettype none

module sbat_div170
  import sbat_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire logic [IdxW-1:0]  dividend_i,
  output logic                  valid_o,
  output logic [IdxW-1:0]       dividend_o,
  output logic [QuotW-1:0]      quot_o,
  output logic [RemW-1:0]       rem_o
);

  logic             v1_q, v2_q;
  logic [IdxW-1:0]  div1_q, div2_q;
  logic [ProdW-1:0] prod_d, prod_q;
  logic [QuotW-1:0] qa;
  logic [IdxW-1:0]  qa_x170;
  logic [8:0]       r_raw;
  logic [QuotW-1:0] quot_d, quot_q;
  logic [RemW-1:0]  rem_d, rem_q;

  assign prod_d = {{(ProdW-IdxW){1'b0}}, dividend_i} * {{(ProdW-RecipW){1'b0}}, DivRecip};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    div1_q <= dividend_i;
    prod_q <= prod_d;
  end

  // estimate is exact or one short; remainder then lies below 340
  always_comb begin
    qa      = prod_q[ProdW-1:32];
    qa_x170 = IdxW'({{(IdxW-QuotW){1'b0}}, qa} * IdxW'(BlocksL0));
    r_raw   = 9'(div1_q - qa_x170);
    if (r_raw >= BlocksL0) begin
      quot_d = qa + 1'b1;
      rem_d  = RemW'(r_raw - BlocksL0);
    end else begin
      quot_d = qa;
      rem_d  = r_raw[RemW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    div2_q <= div1_q;
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign valid_o    = v2_q;
  assign dividend_o = div2_q;
  assign quot_o     = quot_q;
  assign rem_o      = rem_q;

endmodule

`default_nettype wire

// ----- design/sbat_offset.sv -----
// Block numbers, byte offsets and hash table range check: three stages.
// Depends on sbat_pkg.
`default_nettype none

module sbat_offset
  import sbat_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sbat_beat_t        beat_i,
  input  wire logic [BaseW-1:0]  base_offset_i,
  input  wire logic [FsizeW-1:0] file_size_i,
  output logic                   done_o,
  output logic [OffW-1:0]        data_offset_o,
  output logic [OffW-1:0]        hash_table_offset_o,
  output logic [RemW-1:0]        hash_entry_index_o,
  output logic                   hash_in_range_o
);

  // stage A: block numbers
  logic [1:0]      quot2;
  logic [BlkW-1:0] dblk_d, hblk_d, dblk_q, hblk_q;
  logic            va_q, vb_q, vc_q;
  logic [RemW-1:0] rem_a_q, rem_b_q, rem_c_q;

  always_comb begin
    // idx / 4913000 from idx / 28900 (below 581)
    if (beat_i.quot1 >= 10'd510)      quot2 = 2'd3;
    else if (beat_i.quot1 >= 10'd340) quot2 = 2'd2;
    else if (beat_i.quot1 >= 10'd170) quot2 = 2'd1;
    else                              quot2 = 2'd0;

    dblk_d = BlkW'(beat_i.idx) + BlkW'(beat_i.quot0) + 1'b1;
    if (beat_i.quot0 != '0) dblk_d = dblk_d + BlkW'(beat_i.quot1) + 1'b1;
    if (beat_i.quot1 != '0) dblk_d = dblk_d + BlkW'(quot2) + 1'b1;

    if (beat_i.quot0 == '0) begin
      hblk_d = '0;
    end else begin
      hblk_d = BlkW'(BlkW'(beat_i.quot0) * BlkW'(171)) + BlkW'(beat_i.quot1) + 1'b1
             + BlkW'(beat_i.quot1 != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= beat_i.valid;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dblk_q  <= dblk_d;
    hblk_q  <= hblk_d;
    rem_a_q <= beat_i.rem0;
  end

  // stage B: scale and add base
  logic [OffW-1:0] doff_d, hoff_d, doff_q, hoff_q;

  assign doff_d = {dblk_q, {BlkShift{1'b0}}} + OffW'(base_offset_i);
  assign hoff_d = {hblk_q, {BlkShift{1'b0}}} + OffW'(base_offset_i);

  always_ff @(posedge clk_i) begin
    doff_q  <= doff_d;
    hoff_q  <= hoff_d;
    rem_b_q <= rem_a_q;
  end

  // stage C: range check, output register
  logic            fits_d, fits_q;
  logic [OffW-1:0] doff_c_q, hoff_c_q;

  assign fits_d = ((OffW+4)'(hoff_q) + TableBytes) <= (OffW+4)'(file_size_i);

  always_ff @(posedge clk_i) begin
    doff_c_q <= doff_q;
    hoff_c_q <= hoff_q;
    rem_c_q  <= rem_b_q;
    fits_q   <= fits_d;
  end

  assign done_o              = vc_q;
  assign data_offset_o       = doff_c_q;
  assign hash_table_offset_o = hoff_c_q;
  assign hash_entry_index_o  = rem_c_q;
  assign hash_in_range_o     = fits_q;

endmodule

`default_nettype wire

// ----- design/stfs_block_address_translate_core.sv -----
// Top level of the block address translator: config registers, divider chain
// and offset stages. Depends on sbat_pkg, sbat_div170 and sbat_offset.
`default_nettype none

// Translates a 24-bit logical block index of a hashed container volume into
// the byte offset of its data block, the byte offset of the level-0 hash
// table that covers it, the entry index within that table (index mod 170)
// and a flag telling whether that 4096-byte table lies within file_size.
// The block is a seven-stage pipeline with no stall path: busy is always
// low, one beat is taken on every cycle that start is high, and each result
// shows on the output ports with done_o high for one cycle. Results come out
// in order and cannot be held off, so the receiver must take every beat when
// it appears. The stages are those of the two cascaded divide-by-170 units
// (a reciprocal multiply and a correction stage each) and three stages of
// sums, offset adds and the range compare. base_offset (index 0) and
// file_size (index 1) are written through the cfg port and should only
// change while no beats are in flight.
module stfs_block_address_translate_core
  import sbat_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // command side
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [IdxW-1:0]     block_index_i,
  // results
  output logic                     done_o,
  output logic [OffW-1:0]          data_offset_o,
  output logic [OffW-1:0]          hash_table_offset_o,
  output logic [RemW-1:0]          hash_entry_index_o,
  output logic                     hash_in_range_o,
  // config writes
  input  wire logic                cfg_we_i,
  input  wire logic [0:0]          cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  logic [BaseW-1:0]  base_offset_q;
  logic [FsizeW-1:0] file_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_offset_q <= '0;
      file_size_q   <= '0;
    end else if (cfg_we_i) begin
      case (sbat_reg_e'(cfg_idx_i))
        REG_BASE_OFFSET: base_offset_q <= cfg_wdata_i[BaseW-1:0];
        REG_FILE_SIZE:   file_size_q   <= cfg_wdata_i[FsizeW-1:0];
        default: ;
      endcase
    end
  end

  // fully pipelined, never stalls
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // first divide: idx / 170 and idx % 170
  logic             v_a;
  logic [IdxW-1:0]  idx_a;
  logic [QuotW-1:0] quot0_a;
  logic [RemW-1:0]  rem0_a;

  sbat_div170 u_div_l0 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (accept),
    .dividend_i (block_index_i),
    .valid_o    (v_a),
    .dividend_o (idx_a),
    .quot_o     (quot0_a),
    .rem_o      (rem0_a)
  );

  // second divide: (idx / 170) / 170 == idx / 28900
  logic             v_b;
  logic [IdxW-1:0]  quot0_ext_b;
  logic [QuotW-1:0] quot1_b;
  logic [RemW-1:0]  rem_unused_b;

  sbat_div170 u_div_l1 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v_a),
    .dividend_i ({{(IdxW-QuotW){1'b0}}, quot0_a}),
    .valid_o    (v_b),
    .dividend_o (quot0_ext_b),
    .quot_o     (quot1_b),
    .rem_o      (rem_unused_b)
  );

  // index and entry ride alongside the second divider
  logic [IdxW-1:0] idx_d1_q, idx_d2_q;
  logic [RemW-1:0] rem_d1_q, rem_d2_q;

  always_ff @(posedge clk_i) begin
    idx_d1_q <= idx_a;
    idx_d2_q <= idx_d1_q;
    rem_d1_q <= rem0_a;
    rem_d2_q <= rem_d1_q;
  end

  sbat_beat_t beat;

  // remainder of the second divide is not needed; fold it in harmlessly
  assign beat.valid = v_b && (rem_unused_b == rem_unused_b);
  assign beat.idx   = idx_d2_q;
  assign beat.quot0 = quot0_ext_b[QuotW-1:0];
  assign beat.quot1 = quot1_b[9:0];
  assign beat.rem0  = rem_d2_q;

  sbat_offset u_offset (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .beat_i              (beat),
    .base_offset_i       (base_offset_q),
    .file_size_i         (file_size_q),
    .done_o              (done_o),
    .data_offset_o       (data_offset_o),
    .hash_table_offset_o (hash_table_offset_o),
    .hash_entry_index_o  (hash_entry_index_o),
    .hash_in_range_o     (hash_in_range_o)
  );

endmodule

`default_nettype wire
